// ===== design/qpr_pkg.sv =====
// ----------------------------------------------------------------------------
// qpr_pkg
// Shared widths, constants and the half-angle sine table for the quaternion
// point rotation unit.
// ----------------------------------------------------------------------------
package qpr_pkg;

   localparam int QPR_COORD_WIDTH      = 32;
   localparam int QPR_AXIS_WIDTH       = 16;
   localparam int QPR_ANGLE_WIDTH      = 9;
   localparam int QPR_TRIG_WIDTH       = 16;
   localparam int QPR_QV_WIDTH         = 18;
   localparam int QPR_ANGLE_STEPS      = 360;
   localparam int QPR_HALF_STEPS       = QPR_ANGLE_STEPS / 2;
   localparam int QPR_TABLE_IDX_WIDTH  = $clog2(QPR_HALF_STEPS + 1);
   localparam int QPR_HALF_DEG_RAD_Q30 = 9370165;
   localparam int QPR_AXIS_SHIFT       = 14;
   localparam int QPR_FRAC_SHIFT       = 15;
   localparam int QPR_TRIG_MAX         = 32767;
   localparam int QPR_STAGES           = 6;

   typedef logic [QPR_TRIG_WIDTH-2:0] sin_table_type [0:QPR_HALF_STEPS];

   // sine of m half degrees, Q1.15, from a truncated Taylor sum in Q30
   function automatic logic [QPR_TRIG_WIDTH-2:0] qpr_sin_half_deg(input int m);
      logic [63:0]        x;
      logic [63:0]        t;
      logic [63:0]        prod;
      logic signed [63:0] sum;
      x   = 64'(m) * 64'(QPR_HALF_DEG_RAD_Q30);
      t   = x;
      sum = signed'(x);
      for (int k = 1; k <= 7; k++) begin
         t    = (t * x) >> 30;
         prod = (t * x) >> 30;
         case (k)
            1: t = prod / 64'd6;
            2: t = prod / 64'd20;
            3: t = prod / 64'd42;
            4: t = prod / 64'd72;
            5: t = prod / 64'd110;
            6: t = prod / 64'd156;
            default: t = prod / 64'd210;
         endcase
         if (k[0]) begin
            sum = sum - signed'(t);
         end else begin
            sum = sum + signed'(t);
         end
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
         sum = 64'(QPR_TRIG_MAX);
      end
      return sum[QPR_TRIG_WIDTH-2:0];
   endfunction

   function automatic sin_table_type qpr_build_sin_table();
      sin_table_type tbl;
      for (int m = 0; m <= QPR_HALF_STEPS; m++) begin
         tbl[m] = qpr_sin_half_deg(m);
      end
      return tbl;
   endfunction

   localparam sin_table_type QPR_SIN_TABLE = qpr_build_sin_table();

endpackage

// ===== design/qpr_if.sv =====
// ----------------------------------------------------------------------------
// qpr_if
// Valid/ready channels of the quaternion point rotation unit: request beat
// (point, axis, angle) and response beat (rotated point, saturation flag).
// ----------------------------------------------------------------------------
interface qpr_req_if import qpr_pkg::*; #(
   parameter int COORD_WIDTH = QPR_COORD_WIDTH
) ();
   logic                              valid;
   logic                              ready;
   logic signed [COORD_WIDTH-1:0]     point_x;
   logic signed [COORD_WIDTH-1:0]     point_y;
   logic signed [COORD_WIDTH-1:0]     point_z;
   logic signed [QPR_AXIS_WIDTH-1:0]  axis_x;
   logic signed [QPR_AXIS_WIDTH-1:0]  axis_y;
   logic signed [QPR_AXIS_WIDTH-1:0]  axis_z;
   logic [QPR_ANGLE_WIDTH-1:0]        angle_deg;

   modport source (
      output valid, point_x, point_y, point_z, axis_x, axis_y, axis_z, angle_deg,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, point_z, axis_x, axis_y, axis_z, angle_deg,
      output ready
   );
endinterface

interface qpr_rsp_if import qpr_pkg::*; #(
   parameter int COORD_WIDTH = QPR_COORD_WIDTH
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rot_x;
   logic signed [COORD_WIDTH-1:0] rot_y;
   logic signed [COORD_WIDTH-1:0] rot_z;
   logic                          saturated;

   modport source (
      output valid, rot_x, rot_y, rot_z, saturated,
      input  ready
   );
   modport sink (
      input  valid, rot_x, rot_y, rot_z, saturated,
      output ready
   );
endinterface

// ===== design/quaternion_point_rotation_unit.sv =====
// Throughput: one beat per cycle while the response side is not stalled; each
// of the six stages holds one item and an empty stage still fills from behind
// while the response side is stalled.
// The two Hamilton products each take a multiply stage and an add stage.
// Reset clears the stage valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
// quaternion_point_rotation_unit
// Rotates a Q16.16 point by the axis-angle quaternion q as q * p * conj(q),
// saturating the result and flagging any clipped coordinate.
// ----------------------------------------------------------------------------
module quaternion_point_rotation_unit import qpr_pkg::*; #(
   parameter int COORD_WIDTH = QPR_COORD_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   qpr_req_if.sink   req_bus,
   qpr_rsp_if.source rsp_bus
);

   localparam int CW    = COORD_WIDTH;
   localparam int QW    = QPR_QV_WIDTH;
   localparam int TRW   = QPR_TRIG_WIDTH;
   localparam int AW    = QPR_AXIS_WIDTH;
   localparam int AXPW  = AW + TRW;
   localparam int P1W   = CW + QW;
   localparam int TSUMW = P1W + 3;
   localparam int TW    = TSUMW - QPR_FRAC_SHIFT;
   localparam int P2W   = TW + QW;
   localparam int USUMW = P2W + 3;
   localparam int UW    = USUMW - QPR_FRAC_SHIFT;
   localparam int LAST  = QPR_STAGES - 1;

   localparam logic signed [AXPW-1:0]  AX_ROUND = AXPW'(1) << (QPR_AXIS_SHIFT - 1);
   localparam logic signed [TSUMW-1:0] T_ROUND  = TSUMW'(1) << (QPR_FRAC_SHIFT - 1);
   localparam logic signed [USUMW-1:0] U_ROUND  = USUMW'(1) << (QPR_FRAC_SHIFT - 1);
   localparam logic signed [CW-1:0]    SAT_MAX  = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0]    SAT_MIN  = {1'b1, {(CW-1){1'b0}}};

   function automatic logic signed [P1W-1:0] mul_qp(input logic signed [QW-1:0] a,
                                                    input logic signed [CW-1:0] b);
      return P1W'(a) * P1W'(b);
   endfunction

   function automatic logic signed [P2W-1:0] mul_tq(input logic signed [TW-1:0] a,
                                                    input logic signed [QW-1:0] b);
      return P2W'(a) * P2W'(b);
   endfunction

   // stage control
   logic [QPR_STAGES-1:0] valid_ff;
   logic [QPR_STAGES-1:0] valid_in;
   logic [QPR_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[LAST] = ~valid_ff[LAST] | rsp_bus.ready;
      for (int k = LAST - 1; k >= 0; k--) begin
         stage_en[k] = ~valid_ff[k] | stage_en[k+1];
      end
      valid_in[0] = req_bus.valid;
      for (int k = 1; k < QPR_STAGES; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < QPR_STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_bus.ready = stage_en[0];
   assign rsp_bus.valid = valid_ff[LAST];

   // stage 1: half-angle lookup
   logic signed [TRW-1:0] s1_sin_in, s1_cos_in;
   logic signed [TRW-1:0] s1_sin_ff, s1_cos_ff;
   logic signed [AW-1:0]  s1_axis_in [3];
   logic signed [AW-1:0]  s1_axis_ff [3];
   logic signed [CW-1:0]  s1_point_in [3];
   logic signed [CW-1:0]  s1_point_ff [3];

   qpr_half_angle u_half_angle (
      .angle_deg (req_bus.angle_deg),
      .sin_val   (s1_sin_in),
      .cos_val   (s1_cos_in)
   );

   assign s1_axis_in[0]  = req_bus.axis_x;
   assign s1_axis_in[1]  = req_bus.axis_y;
   assign s1_axis_in[2]  = req_bus.axis_z;
   assign s1_point_in[0] = req_bus.point_x;
   assign s1_point_in[1] = req_bus.point_y;
   assign s1_point_in[2] = req_bus.point_z;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_sin_ff   <= s1_sin_in;
         s1_cos_ff   <= s1_cos_in;
         s1_axis_ff  <= s1_axis_in;
         s1_point_ff <= s1_point_in;
      end
   end

   // stage 2: quaternion q = (cos, round(axis * sin))
   logic signed [AXPW-1:0] ax_prod [3];
   logic signed [AXPW-1:0] ax_rnd  [3];
   logic signed [QW-1:0]   s2_q_in [4];
   logic signed [QW-1:0]   s2_q_ff [4];
   logic signed [CW-1:0]   s2_point_ff [3];

   always_comb begin
      s2_q_in[0] = QW'(s1_cos_ff);
      for (int i = 0; i < 3; i++) begin
         ax_prod[i]   = AXPW'(s1_axis_ff[i]) * AXPW'(s1_sin_ff);
         ax_rnd[i]    = (ax_prod[i] + AX_ROUND) >>> QPR_AXIS_SHIFT;
         s2_q_in[i+1] = ax_rnd[i][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s2_q_ff     <= s2_q_in;
         s2_point_ff <= s1_point_ff;
      end
   end

   // stage 3: products of q * p
   logic signed [P1W-1:0] s3_prod_in [12];
   logic signed [P1W-1:0] s3_prod_ff [12];
   logic signed [QW-1:0]  s3_q_ff [4];

   always_comb begin
      s3_prod_in[0]  = mul_qp(s2_q_ff[1], s2_point_ff[0]);
      s3_prod_in[1]  = mul_qp(s2_q_ff[2], s2_point_ff[1]);
      s3_prod_in[2]  = mul_qp(s2_q_ff[3], s2_point_ff[2]);
      s3_prod_in[3]  = mul_qp(s2_q_ff[0], s2_point_ff[0]);
      s3_prod_in[4]  = mul_qp(s2_q_ff[2], s2_point_ff[2]);
      s3_prod_in[5]  = mul_qp(s2_q_ff[3], s2_point_ff[1]);
      s3_prod_in[6]  = mul_qp(s2_q_ff[0], s2_point_ff[1]);
      s3_prod_in[7]  = mul_qp(s2_q_ff[1], s2_point_ff[2]);
      s3_prod_in[8]  = mul_qp(s2_q_ff[3], s2_point_ff[0]);
      s3_prod_in[9]  = mul_qp(s2_q_ff[0], s2_point_ff[2]);
      s3_prod_in[10] = mul_qp(s2_q_ff[1], s2_point_ff[1]);
      s3_prod_in[11] = mul_qp(s2_q_ff[2], s2_point_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s3_prod_ff <= s3_prod_in;
         s3_q_ff    <= s2_q_ff;
      end
   end

   // stage 4: sum and round t = q * p
   logic signed [TSUMW-1:0] t_sum [4];
   logic signed [TSUMW-1:0] t_rnd [4];
   logic signed [TW-1:0]    s4_t_in [4];
   logic signed [TW-1:0]    s4_t_ff [4];
   logic signed [QW-1:0]    s4_q_ff [4];

   always_comb begin
      t_sum[0] = -(TSUMW'(s3_prod_ff[0]) + TSUMW'(s3_prod_ff[1]) + TSUMW'(s3_prod_ff[2]));
      t_sum[1] = TSUMW'(s3_prod_ff[3]) + TSUMW'(s3_prod_ff[4]) - TSUMW'(s3_prod_ff[5]);
      t_sum[2] = TSUMW'(s3_prod_ff[6]) - TSUMW'(s3_prod_ff[7]) + TSUMW'(s3_prod_ff[8]);
      t_sum[3] = TSUMW'(s3_prod_ff[9]) + TSUMW'(s3_prod_ff[10]) - TSUMW'(s3_prod_ff[11]);
      for (int c = 0; c < 4; c++) begin
         t_rnd[c]   = t_sum[c] + T_ROUND;
         s4_t_in[c] = t_rnd[c][TSUMW-1:QPR_FRAC_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s4_t_ff <= s4_t_in;
         s4_q_ff <= s3_q_ff;
      end
   end

   // stage 5: products of t * conj(q), vector part only
   logic signed [P2W-1:0] s5_prod_in [12];
   logic signed [P2W-1:0] s5_prod_ff [12];

   always_comb begin
      s5_prod_in[0]  = mul_tq(s4_t_ff[0], s4_q_ff[1]);
      s5_prod_in[1]  = mul_tq(s4_t_ff[1], s4_q_ff[0]);
      s5_prod_in[2]  = mul_tq(s4_t_ff[2], s4_q_ff[3]);
      s5_prod_in[3]  = mul_tq(s4_t_ff[3], s4_q_ff[2]);
      s5_prod_in[4]  = mul_tq(s4_t_ff[0], s4_q_ff[2]);
      s5_prod_in[5]  = mul_tq(s4_t_ff[1], s4_q_ff[3]);
      s5_prod_in[6]  = mul_tq(s4_t_ff[2], s4_q_ff[0]);
      s5_prod_in[7]  = mul_tq(s4_t_ff[3], s4_q_ff[1]);
      s5_prod_in[8]  = mul_tq(s4_t_ff[0], s4_q_ff[3]);
      s5_prod_in[9]  = mul_tq(s4_t_ff[1], s4_q_ff[2]);
      s5_prod_in[10] = mul_tq(s4_t_ff[2], s4_q_ff[1]);
      s5_prod_in[11] = mul_tq(s4_t_ff[3], s4_q_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s5_prod_ff <= s5_prod_in;
      end
   end

   // stage 6: sum, round and saturate
   logic signed [USUMW-1:0] u_sum [3];
   logic signed [USUMW-1:0] u_rnd [3];
   logic signed [UW-1:0]    u_val [3];
   logic [2:0]              u_over;
   logic signed [CW-1:0]    s6_rot_in [3];
   logic signed [CW-1:0]    s6_rot_ff [3];
   logic                    s6_sat_in;
   logic                    s6_sat_ff;

   always_comb begin
      u_sum[0] = -USUMW'(s5_prod_ff[0]) + USUMW'(s5_prod_ff[1])
                 - USUMW'(s5_prod_ff[2]) + USUMW'(s5_prod_ff[3]);
      u_sum[1] = -USUMW'(s5_prod_ff[4]) + USUMW'(s5_prod_ff[5])
                 + USUMW'(s5_prod_ff[6]) - USUMW'(s5_prod_ff[7]);
      u_sum[2] = -USUMW'(s5_prod_ff[8]) - USUMW'(s5_prod_ff[9])
                 + USUMW'(s5_prod_ff[10]) + USUMW'(s5_prod_ff[11]);
      for (int c = 0; c < 3; c++) begin
         u_rnd[c]  = u_sum[c] + U_ROUND;
         u_val[c]  = u_rnd[c][USUMW-1:QPR_FRAC_SHIFT];
         u_over[c] = ~(&u_val[c][UW-1:CW-1]) & (|u_val[c][UW-1:CW-1]);
         if (u_over[c]) begin
            s6_rot_in[c] = u_val[c][UW-1] ? SAT_MIN : SAT_MAX;
         end else begin
            s6_rot_in[c] = u_val[c][CW-1:0];
         end
      end
      s6_sat_in = |u_over;
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s6_rot_ff <= s6_rot_in;
         s6_sat_ff <= s6_sat_in;
      end
   end

   assign rsp_bus.rot_x     = s6_rot_ff[0];
   assign rsp_bus.rot_y     = s6_rot_ff[1];
   assign rsp_bus.rot_z     = s6_rot_ff[2];
   assign rsp_bus.saturated = s6_sat_ff;

endmodule

// ===== design/qpr_half_angle.sv =====
// ----------------------------------------------------------------------------
// qpr_half_angle
// Reduces the angle modulo one turn and looks up sine and cosine of the half
// angle, Q1.15, using quadrant identities on a half-turn table.
// ----------------------------------------------------------------------------
module qpr_half_angle import qpr_pkg::*; (
   input  logic [QPR_ANGLE_WIDTH-1:0]       angle_deg,
   output logic signed [QPR_TRIG_WIDTH-1:0] sin_val,
   output logic signed [QPR_TRIG_WIDTH-1:0] cos_val
);

   localparam logic [QPR_ANGLE_WIDTH-1:0] STEPS = QPR_ANGLE_WIDTH'(QPR_ANGLE_STEPS);
   localparam logic [QPR_ANGLE_WIDTH-1:0] HALF  = QPR_ANGLE_WIDTH'(QPR_HALF_STEPS);

   logic [QPR_ANGLE_WIDTH-1:0]      n;
   logic [QPR_TABLE_IDX_WIDTH-1:0]  sin_idx;
   logic [QPR_TABLE_IDX_WIDTH-1:0]  cos_idx;
   logic                            cos_neg;
   logic signed [QPR_TRIG_WIDTH-1:0] cos_mag;

   always_comb begin
      n = (angle_deg >= STEPS) ? angle_deg - STEPS : angle_deg;
      if (n <= HALF) begin
         sin_idx = QPR_TABLE_IDX_WIDTH'(n);
         cos_idx = QPR_TABLE_IDX_WIDTH'(HALF - n);
         cos_neg = 1'b0;
      end else begin
         sin_idx = QPR_TABLE_IDX_WIDTH'(STEPS - n);
         cos_idx = QPR_TABLE_IDX_WIDTH'(n - HALF);
         cos_neg = 1'b1;
      end
      sin_val = signed'({1'b0, QPR_SIN_TABLE[sin_idx]});
      cos_mag = signed'({1'b0, QPR_SIN_TABLE[cos_idx]});
      cos_val = cos_neg ? -cos_mag : cos_mag;
   end

endmodule

// ===== design/qpr_checker.sv =====
// ----------------------------------------------------------------------------
// qpr_checker
// Port-level checks for the quaternion point rotation unit: response hold,
// reset, beat accounting against pipeline depth and saturation flag.
// ----------------------------------------------------------------------------
module qpr_checker import qpr_pkg::*; #(
   parameter int COORD_WIDTH = QPR_COORD_WIDTH
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_WIDTH-1:0] rot_x,
   input logic signed [COORD_WIDTH-1:0] rot_y,
   input logic signed [COORD_WIDTH-1:0] rot_z,
   input logic                          rsp_saturated
);

   localparam int CNT_W = $clog2(QPR_STAGES + 1) + 1;
   localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;

   assign pending_in = pending_ff + CNT_W'(req_valid && req_ready)
                       - CNT_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response beat without a pending request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(QPR_STAGES))
      else $error("more items in flight than pipeline stages");

   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rot_x == SAT_MAX || rot_x == SAT_MIN || rot_y == SAT_MAX ||
         rot_y == SAT_MIN || rot_z == SAT_MAX || rot_z == SAT_MIN)
      else $error("saturation flag without a clipped coordinate");

endmodule

bind quaternion_point_rotation_unit qpr_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_qpr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rot_x         (rsp_bus.rot_x),
   .rot_y         (rsp_bus.rot_y),
   .rot_z         (rsp_bus.rot_z),
   .rsp_saturated (rsp_bus.saturated)
);
